// ===== rtl/svpwm_pkg.sv =====
// Shared constants and types for the space-vector PWM sector timing block.
// Used by svpwm_sector_timing and its port checker; depends on nothing else.
package svpwm_pkg;

   // Number formats: inputs are signed Q1.15, depth is unsigned Q1.15.
   localparam int FRAC_BITS  = 15;
   localparam int DEPTH_BITS = 15;
   localparam int ONE_SHIFT  = DEPTH_BITS + FRAC_BITS;

   // 1/sqrt(3) in Q0.16, kept one bit wider so it multiplies as a positive signed value.
   localparam logic [16:0] INV_SQRT3_Q16 = 17'd37837;

   // Datapath widths.
   localparam int U_W   = 18;  // active-vector components
   localparam int MU_W  = 34;  // depth times component
   localparam int Z_W   = 35;  // zero-vector term before the period multiply
   localparam int ACC_W = 56;  // count numerators over 2*D
   localparam int R_W   = 23;  // rounded count before the clamp

   // Pipeline depth, acceptance to result.
   localparam int NSTG = 9;

   // Configuration registers.
   localparam int          CSR_ADDR_W    = 3;
   localparam logic        CSR_IDX_PERIOD = 1'b0;
   localparam logic        CSR_IDX_DEPTH  = 1'b1;
   localparam logic [15:0] PERIOD_RESET   = 16'd5600;
   localparam logic [15:0] DEPTH_RESET    = 16'd26214;

   typedef logic [2:0]                 sector_type;
   typedef logic signed [U_W-1:0]      comp_type;
   typedef logic signed [MU_W-1:0]     mu_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic [R_W-1:0]             cnt_type;

   localparam sector_type SECTOR_1 = 3'd1;
   localparam sector_type SECTOR_2 = 3'd2;
   localparam sector_type SECTOR_3 = 3'd3;
   localparam sector_type SECTOR_4 = 3'd4;
   localparam sector_type SECTOR_5 = 3'd5;
   localparam sector_type SECTOR_6 = 3'd6;

endpackage

// ===== rtl/svpwm_sector_timing.sv =====
// A result shows on rsp_valid once its request has passed through all 9 register stages.
// Throughput: one request per cycle; each stage holds its contents only while the stage
// after it is full and held, so bubbles close up and req_stall rises only when all 9 stages
// are full and rsp_stall is high. Reset (synchronous) clears every stage valid bit and
// returns pwm_period to 5600 and modulation_depth to 26214. Depends on svpwm_pkg.
module svpwm_sector_timing (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [15:0]                 req_alpha_voltage,
   input  logic signed [15:0]                 req_beta_voltage,
   // Result channel.
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [15:0]                        rsp_compare_u,
   output logic [15:0]                        rsp_compare_v,
   output logic [15:0]                        rsp_compare_w,
   output logic [2:0]                         rsp_sector_number,
   // Register port.
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [svpwm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   // ------------------------------------------------------------------
   // Configuration registers. The user must change them only while the
   // pipeline is empty; the block itself does not enforce this. Every stage reads them directly.
   // ------------------------------------------------------------------
   logic [15:0] period_ff, period_in;
   logic [15:0] depth_ff, depth_in;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      period_in = period_ff;
      depth_in  = depth_ff;
      if (csr_wr) begin
         if (paddr[2] == svpwm_pkg::CSR_IDX_DEPTH) begin
            depth_in = pwdata[15:0];
         end else begin
            period_in = pwdata[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= svpwm_pkg::PERIOD_RESET;
         depth_ff  <= svpwm_pkg::DEPTH_RESET;
      end else begin
         period_ff <= period_in;
         depth_ff  <= depth_in;
      end
   end

   assign prdata = (paddr[2] == svpwm_pkg::CSR_IDX_DEPTH) ? {16'd0, depth_ff}
                                                          : {16'd0, period_ff};

   logic signed [16:0] period_s;
   logic signed [16:0] depth_s;
   assign period_s = $signed({1'b0, period_ff});
   assign depth_s  = $signed({1'b0, depth_ff});

   // ------------------------------------------------------------------
   // Stage control. A stage loads when it is empty or when the stage
   // after it loads; the output register loads when it is empty or the
   // result is being taken.
   // ------------------------------------------------------------------
   logic [svpwm_pkg::NSTG:1] vld_ff, vld_in;
   logic [svpwm_pkg::NSTG:1] load;

   always_comb begin
      load[svpwm_pkg::NSTG] = !vld_ff[svpwm_pkg::NSTG] || !rsp_stall;
      for (int k = svpwm_pkg::NSTG - 1; k >= 1; k--) begin
         load[k] = !vld_ff[k] || load[k+1];
      end
      vld_in = vld_ff;
      if (load[1]) begin
         vld_in[1] = req_valid;
      end
      for (int k = 2; k <= svpwm_pkg::NSTG; k++) begin
         if (load[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !load[1];
   assign rsp_valid = vld_ff[svpwm_pkg::NSTG];

   // ------------------------------------------------------------------
   // Stage 1: capture alpha and multiply beta by 1/sqrt(3) in Q0.16.
   // ------------------------------------------------------------------
   logic signed [15:0] a1_ff;
   logic signed [15:0] b1_ff;
   logic signed [32:0] prod1_ff, prod1_in;

   assign prod1_in = req_beta_voltage * $signed(svpwm_pkg::INV_SQRT3_Q16);

   always_ff @(posedge clock) begin
      if (load[1]) begin
         a1_ff    <= req_alpha_voltage;
         b1_ff    <= req_beta_voltage;
         prod1_ff <= prod1_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: round beta/sqrt(3) half up, find the sector by comparing
   // alpha with plus and minus that value, and form the two active-vector
   // components of the sector.
   // ------------------------------------------------------------------
   logic signed [33:0]             b3_sum;
   svpwm_pkg::comp_type            a18, b3, nb3;
   svpwm_pkg::sector_type          sec2_in, sec2_ff;
   svpwm_pkg::comp_type            u1_in, u2_in, u1_ff, u2_ff;

   always_comb begin
      b3_sum = {prod1_ff[32], prod1_ff} + 34'sd32768;
      b3     = b3_sum[33:16];
      nb3    = -b3;
      a18    = {{2{a1_ff[15]}}, a1_ff};

      if (!b1_ff[15]) begin
         if (a18 > b3) begin
            sec2_in = svpwm_pkg::SECTOR_1;
         end else if (a18 > nb3) begin
            sec2_in = svpwm_pkg::SECTOR_2;
         end else begin
            sec2_in = svpwm_pkg::SECTOR_3;
         end
      end else begin
         if (a18 >= nb3) begin
            sec2_in = svpwm_pkg::SECTOR_6;
         end else if (a18 > b3) begin
            sec2_in = svpwm_pkg::SECTOR_5;
         end else begin
            sec2_in = svpwm_pkg::SECTOR_4;
         end
      end

      case (sec2_in)
         svpwm_pkg::SECTOR_1: begin
            u1_in = a18 - b3;
            u2_in = b3 + b3;
         end
         svpwm_pkg::SECTOR_2: begin
            u1_in = a18 + b3;
            u2_in = b3 - a18;
         end
         svpwm_pkg::SECTOR_3: begin
            u1_in = b3 + b3;
            u2_in = nb3 - a18;
         end
         svpwm_pkg::SECTOR_4: begin
            u1_in = b3 - a18;
            u2_in = nb3 + nb3;
         end
         svpwm_pkg::SECTOR_5: begin
            u1_in = nb3 - a18;
            u2_in = a18 - b3;
         end
         default: begin
            u1_in = nb3 + nb3;
            u2_in = a18 + b3;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         sec2_ff <= sec2_in;
         u1_ff   <= u1_in;
         u2_ff   <= u2_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: scale both components by the modulation depth.
   // ------------------------------------------------------------------
   logic signed [34:0]    mu1_full, mu2_full;
   svpwm_pkg::mu_type     mu1_3_ff, mu2_3_ff;
   svpwm_pkg::sector_type sec3_ff;

   assign mu1_full = depth_s * u1_ff;
   assign mu2_full = depth_s * u2_ff;

   always_ff @(posedge clock) begin
      if (load[3]) begin
         mu1_3_ff <= mu1_full[svpwm_pkg::MU_W-1:0];
         mu2_3_ff <= mu2_full[svpwm_pkg::MU_W-1:0];
         sec3_ff  <= sec2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: zero-vector term, 1.0 minus the scaled component sum.
   // ------------------------------------------------------------------
   localparam logic [svpwm_pkg::Z_W-1:0] ONE_Z =
      svpwm_pkg::Z_W'(64'd1 << svpwm_pkg::ONE_SHIFT);

   logic [svpwm_pkg::Z_W-1:0]        z_in;
   logic signed [svpwm_pkg::Z_W-1:0] z_ff;
   svpwm_pkg::mu_type                mu1_4_ff, mu2_4_ff;
   svpwm_pkg::sector_type            sec4_ff;

   assign z_in = ONE_Z - {mu1_3_ff[svpwm_pkg::MU_W-1], mu1_3_ff}
                       - {mu2_3_ff[svpwm_pkg::MU_W-1], mu2_3_ff};

   always_ff @(posedge clock) begin
      if (load[4]) begin
         z_ff     <= z_in;
         mu1_4_ff <= mu1_3_ff;
         mu2_4_ff <= mu2_3_ff;
         sec4_ff  <= sec3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: multiply by the period. The zero-vector numerator is
   // already over 2*D; the active terms are doubled to match.
   // ------------------------------------------------------------------
   logic signed [svpwm_pkg::Z_W+16:0]  n0_full;
   logic signed [svpwm_pkg::MU_W+16:0] s1_full, s2_full;
   svpwm_pkg::acc_type                 n0_5_ff, s1_5_ff, s2_5_ff;
   svpwm_pkg::sector_type              sec5_ff;

   assign n0_full = z_ff * period_s;
   assign s1_full = mu1_4_ff * period_s;
   assign s2_full = mu2_4_ff * period_s;

   always_ff @(posedge clock) begin
      if (load[5]) begin
         n0_5_ff <= {{(svpwm_pkg::ACC_W-svpwm_pkg::Z_W-17){n0_full[svpwm_pkg::Z_W+16]}},
                     n0_full};
         s1_5_ff <= {{(svpwm_pkg::ACC_W-svpwm_pkg::MU_W-18){s1_full[svpwm_pkg::MU_W+16]}},
                     s1_full, 1'b0};
         s2_5_ff <= {{(svpwm_pkg::ACC_W-svpwm_pkg::MU_W-18){s2_full[svpwm_pkg::MU_W+16]}},
                     s2_full, 1'b0};
         sec5_ff <= sec4_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: first cumulative addition. Odd sectors add the second
   // component first, even sectors the first component.
   // ------------------------------------------------------------------
   svpwm_pkg::acc_type    n0_6_ff, mid6_ff, next6_ff;
   svpwm_pkg::sector_type sec6_ff;

   always_ff @(posedge clock) begin
      if (load[6]) begin
         n0_6_ff  <= n0_5_ff;
         mid6_ff  <= n0_5_ff + (sec5_ff[0] ? s2_5_ff : s1_5_ff);
         next6_ff <= sec5_ff[0] ? s1_5_ff : s2_5_ff;
         sec6_ff  <= sec5_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: second cumulative addition.
   // ------------------------------------------------------------------
   svpwm_pkg::acc_type    n0_7_ff, mid7_ff, last7_ff;
   svpwm_pkg::sector_type sec7_ff;

   always_ff @(posedge clock) begin
      if (load[7]) begin
         n0_7_ff  <= n0_6_ff;
         mid7_ff  <= mid6_ff;
         last7_ff <= mid6_ff + next6_ff;
         sec7_ff  <= sec6_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 8: round each numerator half up to a count; a negative
   // numerator gives zero.
   // ------------------------------------------------------------------
   localparam svpwm_pkg::acc_type ROUND_ADD =
      svpwm_pkg::ACC_W'(64'd1 << svpwm_pkg::ONE_SHIFT);

   function automatic svpwm_pkg::cnt_type round_count(input svpwm_pkg::acc_type n);
      svpwm_pkg::acc_type sum;
      sum = n + ROUND_ADD;
      if (n[svpwm_pkg::ACC_W-1]) begin
         return '0;
      end
      return sum[svpwm_pkg::ONE_SHIFT+1 +: svpwm_pkg::R_W];
   endfunction

   svpwm_pkg::cnt_type    r0_ff, rmid_ff, rlast_ff;
   svpwm_pkg::sector_type sec8_ff;

   always_ff @(posedge clock) begin
      if (load[8]) begin
         r0_ff    <= round_count(n0_7_ff);
         rmid_ff  <= round_count(mid7_ff);
         rlast_ff <= round_count(last7_ff);
         sec8_ff  <= sec7_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 9 (output register): clamp to the period and route the zero,
   // middle and last counts to phases U, V and W by sector.
   // ------------------------------------------------------------------
   function automatic logic [15:0] clamp_count(input svpwm_pkg::cnt_type r,
                                               input logic [15:0] p);
      if (r > {{(svpwm_pkg::R_W-16){1'b0}}, p}) begin
         return p;
      end
      return r[15:0];
   endfunction

   logic [15:0] c0, cmid, clast;
   logic [15:0] cu_in, cv_in, cw_in;
   logic [15:0] cu_ff, cv_ff, cw_ff;
   svpwm_pkg::sector_type sec9_ff;

   always_comb begin
      c0    = clamp_count(r0_ff, period_ff);
      cmid  = clamp_count(rmid_ff, period_ff);
      clast = clamp_count(rlast_ff, period_ff);
      case (sec8_ff)
         svpwm_pkg::SECTOR_1: begin
            cw_in = c0;   cv_in = cmid; cu_in = clast;
         end
         svpwm_pkg::SECTOR_2: begin
            cw_in = c0;   cu_in = cmid; cv_in = clast;
         end
         svpwm_pkg::SECTOR_3: begin
            cu_in = c0;   cw_in = cmid; cv_in = clast;
         end
         svpwm_pkg::SECTOR_4: begin
            cu_in = c0;   cv_in = cmid; cw_in = clast;
         end
         svpwm_pkg::SECTOR_5: begin
            cv_in = c0;   cu_in = cmid; cw_in = clast;
         end
         default: begin
            cv_in = c0;   cw_in = cmid; cu_in = clast;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load[9]) begin
         cu_ff   <= cu_in;
         cv_ff   <= cv_in;
         cw_ff   <= cw_in;
         sec9_ff <= sec8_ff;
      end
   end

   assign rsp_compare_u     = cu_ff;
   assign rsp_compare_v     = cv_ff;
   assign rsp_compare_w     = cw_ff;
   assign rsp_sector_number = sec9_ff;

endmodule

// ===== rtl/svpwm_chk.sv =====
// Port-level checker for svpwm_sector_timing, bound to the top level below.
// Depends on svpwm_pkg for the register reset value and register index.
module svpwm_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [15:0]                      rsp_compare_u,
   input logic [15:0]                      rsp_compare_v,
   input logic [15:0]                      rsp_compare_w,
   input logic [2:0]                       rsp_sector_number,
   input logic                             psel,
   input logic                             penable,
   input logic                             pwrite,
   input logic                             pready,
   input logic [svpwm_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [31:0]                      pwdata
);

   // Copy of the period as written through the register port.
   logic [15:0] period_ff, period_in;

   always_comb begin
      period_in = period_ff;
      if (psel && penable && pwrite && pready
          && paddr[2] == svpwm_pkg::CSR_IDX_PERIOD) begin
         period_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= svpwm_pkg::PERIOD_RESET;
      end else begin
         period_ff <= period_in;
      end
   end

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Every result lies in one of the six sectors.
   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sector_number != 3'd0 && rsp_sector_number != 3'd7))
      else $error("sector number out of range");

   // Compare counts never exceed the period.
   a_count_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_compare_u <= period_ff && rsp_compare_v <= period_ff
                     && rsp_compare_w <= period_ff))
      else $error("compare count above period");

   // A held result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_compare_u)
         && $stable(rsp_compare_v) && $stable(rsp_compare_w)
         && $stable(rsp_sector_number))
      else $error("held result changed");

endmodule

bind svpwm_sector_timing svpwm_chk u_svpwm_chk (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_compare_u     (rsp_compare_u),
   .rsp_compare_v     (rsp_compare_v),
   .rsp_compare_w     (rsp_compare_w),
   .rsp_sector_number (rsp_sector_number),
   .psel              (psel),
   .penable           (penable),
   .pwrite            (pwrite),
   .pready            (pready),
   .paddr             (paddr),
   .pwdata            (pwdata)
);
